// ===== design/cbp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_pkg
// Shared types and the counter update rule of the correlating branch
// predictor.
// ---------------------------------------------------------------------------
package cbp_pkg;

    typedef logic [1:0] ctr_t;

    // Every counter comes out of reset at its strongest taken value.
    localparam ctr_t CTR_RESET = 2'd3;
    localparam ctr_t CTR_ZERO  = 2'd0;
    localparam ctr_t CTR_ONE   = 2'd1;
    localparam ctr_t CTR_TWO   = 2'd2;
    localparam ctr_t CTR_THREE = 2'd3;

    // Taken moves zero to one and anything else to three; not taken moves
    // three to two and anything else to zero.
    function automatic ctr_t next_ctr(input ctr_t cur, input logic outcome);
        ctr_t res;
        if (outcome)
        begin
            res = (cur == CTR_ZERO) ? CTR_ONE : CTR_THREE;
        end
        else
        begin
            res = (cur == CTR_THREE) ? CTR_TWO : CTR_ZERO;
        end
        return res;
    endfunction

endpackage

// ===== design/cbp_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_table
// Counter memory with one read port (registered data) and one write port.
// After reset a sweep writes the reset value into every entry.
// ---------------------------------------------------------------------------
module cbp_table #(
    parameter int IDX_W = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output cbp_pkg::ctr_t       rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  cbp_pkg::ctr_t       wr_data,
    output logic                clr_busy
);

    localparam int DEPTH = 1 << IDX_W;

    cbp_pkg::ctr_t      mem [0:DEPTH-1];
    cbp_pkg::ctr_t      rd_data_reg;
    logic               clr_busy_reg;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic               clr_last;

    assign clr_last = (clr_addr_reg == {IDX_W{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_last)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= cbp_pkg::CTR_RESET;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

`ifndef SYNTHESIS
    a_clr_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_busy_reg && clr_last) |=> !clr_busy_reg)
        else $error("clear sweep did not finish at the last entry");
    a_no_wr_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !wr_en)
        else $error("write requested during the clear sweep");
`endif

endmodule

// ===== design/correlating_branch_predictor_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// correlating_branch_predictor_core
// (m,k) correlating branch predictor: a global outcome history joined with
// the low address bits selects a 2-bit counter that gives the prediction.
//
//   channel   signals                   word
//   input     in_valid, in_ready        pc, taken (resolved branch)
//   output    out_valid, out_ready      predict_taken
//
// One word per cycle is accepted while in_ready is high; its prediction is taken
// in the second stage and registered at the output. The counter memory is read
// at accept and written back as the word leaves the second stage, forwarding the
// written value to a following word on the same entry. After reset a clear sweep
// over all 2^(HIST_BITS+PC_BITS) entries (4096 by default) fills the memory;
// in_ready stays low during it. When out_ready is low the result holds and
// in_ready drops once the second stage is also occupied.
// ---------------------------------------------------------------------------
module correlating_branch_predictor_core #(
    parameter int HIST_BITS = 2,
    parameter int PC_BITS   = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pc,
    input  logic        taken,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        predict_taken
);

    localparam int IDX_W = HIST_BITS + PC_BITS;

    logic [HIST_BITS-1:0]   hist_reg;
    logic [HIST_BITS-1:0]   hist_next;
    logic [HIST_BITS:0]     hist_shift;
    logic [IDX_W-1:0]       idx_in;
    logic                   acc;
    logic                   clr_busy;
    cbp_pkg::ctr_t          rd_data;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic                   s1_taken_reg;
    logic                   fwd_hit_reg;
    cbp_pkg::ctr_t          fwd_data_reg;
    cbp_pkg::ctr_t          s1_ctr;
    cbp_pkg::ctr_t          s1_new;
    logic                   s1_move;
    logic                   s1_wr;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   predict_reg;

    assign hist_shift = {hist_reg, taken};
    assign hist_next  = hist_shift[HIST_BITS-1:0];
    assign idx_in     = {hist_reg, pc[PC_BITS-1:0]};

    assign s1_move  = !out_valid_reg || out_ready;
    assign in_ready = !clr_busy && (!s1_valid_reg || s1_move);
    assign acc      = in_valid && in_ready;

    // The memory read lags any write issued at the same edge, so that
    // write is captured here and takes precedence over the read data.
    assign s1_ctr = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign s1_new = cbp_pkg::next_ctr(s1_ctr, s1_taken_reg);
    assign s1_wr  = s1_valid_reg && s1_move;

    assign s1_valid_next  = acc || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_wr || (out_valid_reg && !out_ready);

    cbp_table #(
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (acc),
        .rd_addr  (idx_in),
        .rd_data  (rd_data),
        .wr_en    (s1_wr),
        .wr_addr  (s1_idx_reg),
        .wr_data  (s1_new),
        .clr_busy (clr_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= {HIST_BITS{1'b1}};
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (acc)
            begin
                hist_reg    <= hist_next;
                fwd_hit_reg <= s1_wr && (s1_idx_reg == idx_in);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_idx_reg   <= idx_in;
            s1_taken_reg <= taken;
            fwd_data_reg <= s1_new;
        end
        if (s1_wr)
        begin
            predict_reg <= s1_ctr[1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign predict_taken = predict_reg;

`ifndef SYNTHESIS
    a_no_acc_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> !clr_busy)
        else $error("word accepted during the clear sweep");
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("second stage lost its word while stalled");
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s1_wr && (s1_idx_reg == idx_in)) |=> fwd_hit_reg)
        else $error("same-entry write was not forwarded");
    a_hist: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (hist_reg == $past(hist_next)))
        else $error("history not shifted on accept");
`endif

endmodule

// ===== sim/tb_correlating_branch_predictor_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_correlating_branch_predictor_core
// Self-checking testbench for the correlating branch predictor. A local copy
// of the history register and the counter table predicts every outcome. Each
// prediction the block returns is compared in order with that copy. The
// stimulus covers reset counters, a walk through counter transitions, address
// aliasing, and random loop-like branch streams with random input gaps and
// output stalls.
// ---------------------------------------------------------------------------
module tb_correlating_branch_predictor_core;

    localparam int HIST_BITS      = 2;
    localparam int PC_BITS        = 10;
    localparam int TABLE_ENTRIES  = 1 << (HIST_BITS + PC_BITS);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOT_BRANCHES   = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [31:0] pc            = 32'd0;
    logic        taken         = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        predict_taken;

    // Local copy of the predictor state.
    logic [HIST_BITS-1:0] branch_hist;
    cbp_pkg::ctr_t        ctr_mem [TABLE_ENTRIES];

    logic pending_predictions [$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    int   stall_left     = 0;
    int   stall_len;
    bit   in_gaps_on     = 1'b0;
    bit   out_stalls_on  = 1'b0;

    logic [31:0] hot_pc   [HOT_BRANCHES];
    int          loop_len [HOT_BRANCHES];
    int          loop_pos [HOT_BRANCHES];

    correlating_branch_predictor_core #(
        .HIST_BITS (HIST_BITS),
        .PC_BITS   (PC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pc            (pc),
        .taken         (taken),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .predict_taken (predict_taken)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void reset_predictor_state();
        branch_hist = '1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ctr_mem[i] = cbp_pkg::CTR_THREE;
        end
    endfunction

    // Returns the prediction for one resolved branch and then trains on it.
    function automatic logic predict_and_train(input logic [31:0] addr,
                                               input logic outcome);
        logic [HIST_BITS+PC_BITS-1:0] idx;
        cbp_pkg::ctr_t                cur;
        logic                         guess;
        idx   = {branch_hist, addr[PC_BITS-1:0]};
        cur   = ctr_mem[idx];
        guess = cur[1];
        unique case (cur)
            cbp_pkg::CTR_ZERO:
                ctr_mem[idx] = outcome ? cbp_pkg::CTR_ONE : cbp_pkg::CTR_ZERO;
            cbp_pkg::CTR_ONE:
                ctr_mem[idx] = outcome ? cbp_pkg::CTR_THREE : cbp_pkg::CTR_ZERO;
            cbp_pkg::CTR_TWO:
                ctr_mem[idx] = outcome ? cbp_pkg::CTR_THREE : cbp_pkg::CTR_ZERO;
            default:
                ctr_mem[idx] = outcome ? cbp_pkg::CTR_THREE : cbp_pkg::CTR_TWO;
        endcase
        branch_hist = {branch_hist[HIST_BITS-2:0], outcome};
        return guess;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drives one branch word and returns at the edge that accepts it.
    task automatic send_branch(input logic [31:0] addr, input logic outcome);
        int gap;
        gap = pick_gap(in_gaps_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pc       <= addr;
        taken    <= outcome;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_predictions.insert(pending_predictions.size(),
                                   predict_and_train(addr, outcome));
    endtask

    // Output side: random stretches of out_ready low.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_len = pick_gap(out_stalls_on);
            out_ready  <= (stall_len == 0);
            stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_predictions.size() == 0)
            begin
                report_mismatch($sformatf("prediction %0b with none expected",
                                          predict_taken));
            end
            else if (predict_taken !== pending_predictions[0])
            begin
                report_mismatch($sformatf("predict_taken %0b, expected %0b",
                                          predict_taken, pending_predictions[0]));
                void'(pending_predictions.pop_front());
            end
            else
            begin
                void'(pending_predictions.pop_front());
            end
        end
    end

    // Ends the run if neither channel moves for too long; the window covers
    // the clear sweep after reset.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Fresh entries all start at three, so every first visit predicts taken.
    task automatic test_reset_counters();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'h0000_03FF, 1'b1);
        send_branch(32'h5555_5555, 1'b1);
        send_branch(32'hAAAA_AAAA, 1'b1);
    endtask

    // Walks one address through a series of counter transitions, back to back so
    // that repeated hits on one entry need the write-back forwarding.
    task automatic test_counter_walk();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b1);
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b0);
        send_branch(32'h0000_0123, 1'b1);
        send_branch(32'h0000_0123, 1'b1);
        send_branch(32'h0000_0123, 1'b1);
    endtask

    // Addresses that differ only above the PC index bits share a counter when the history matches.
    task automatic test_address_alias();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b0;
        send_branch(32'h0000_0200, 1'b0);
        send_branch(32'hFFFF_FE00, 1'b0);
        send_branch(32'h1234_5600, 1'b0);
        send_branch(32'h8000_0200, 1'b1);
        send_branch(32'h7FFF_FE00, 1'b1);
        send_branch(32'h8000_0000, 1'b0);
    endtask

    // Loop-like streams on a few hot branches, with some flipped outcomes
    // and some fully random branches mixed in.
    task automatic test_random_branches(input int count, input bit gaps,
                                        input bit stalls);
        int          b;
        int          r;
        logic [31:0] addr;
        logic        outcome;
        in_gaps_on    = gaps;
        out_stalls_on = stalls;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                b    = $urandom_range(0, HOT_BRANCHES - 1);
                addr = hot_pc[b];
                if (($urandom_range(0, 3) == 0))
                begin
                    addr[31:PC_BITS] = (32 - PC_BITS)'($urandom);
                end
                outcome = (loop_pos[b] < loop_len[b]);
                loop_pos[b] = outcome ? loop_pos[b] + 1 : 0;
                if (r < 8)
                begin
                    outcome = ~outcome;
                end
            end
            else
            begin
                addr    = $urandom;
                outcome = 1'($urandom_range(0, 1));
            end
            send_branch(addr, outcome);
        end
    endtask

    initial
    begin
        reset_predictor_state();
        for (int i = 0; i < HOT_BRANCHES; i++)
        begin
            hot_pc[i]   = $urandom;
            loop_len[i] = $urandom_range(0, 6);
            loop_pos[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_counters();
        test_counter_walk();
        test_address_alias();
        test_random_branches(150, 1'b0, 1'b0);
        test_random_branches(350, 1'b1, 1'b1);
        test_random_branches(150, 1'b0, 1'b1);

        in_valid      <= 1'b0;
        out_stalls_on  = 1'b1;
        while (pending_predictions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== correlating_branch_predictor_core.f =====
design/cbp_pkg.sv
design/cbp_table.sv
design/correlating_branch_predictor_core.sv
sim/tb_correlating_branch_predictor_core.sv
